// ===== rtl/pcsd_pkg.sv =====
package pcsd_pkg;

  localparam int unsigned PlaneCountDefault = 3;
  localparam logic [15:0] TickPsReset       = 16'd25000;

  localparam logic [7:0] TrigHdrByte = 8'h88;
  localparam logic [7:0] TsHdrByte   = 8'h80;
  localparam logic [7:0] RegionReset = 8'hFF;
  localparam logic [3:0] NibIdle     = 4'hF;
  localparam logic [3:0] NibEmpty    = 4'hE;
  localparam logic [3:0] NibChipHdr  = 4'hA;
  localparam logic [2:0] RegionTag   = 3'b110;
  localparam logic [1:0] DataTag     = 2'b01;
  localparam logic [2:0] TrigLast    = 3'd3;
  localparam logic [2:0] TsLast      = 3'd5;

  typedef enum logic [2:0] {
    PH_HDR   = 3'd0,
    PH_TRIG  = 3'd1,
    PH_TSCHK = 3'd2,
    PH_TS    = 3'd3,
    PH_BODY  = 3'd4,
    PH_DATA2 = 3'd5,
    PH_SKIP  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_TRIG = 2'd1,
    KIND_TS   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
    logic [1:0] plane;
  } item_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [1:0]  plane;
    logic [12:0] column;
    logic [8:0]  row;
    logic [47:0] value;
  } result_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] region;
    logic [5:0] pend;
    logic       stop;
  } body_t;

  // Body byte decode; never yields a result.
  function automatic body_t body_byte(input body_t cur, input logic [7:0] b);
    body_t nxt;
    nxt = cur;
    if (b[7:4] == NibIdle) begin
      nxt = cur;
    end else if (b[7:4] == NibEmpty) begin
      nxt.stop = 1'b1;
    end else if (b[7:4] == NibChipHdr) begin
      nxt.phase = PH_SKIP;
    end else if (b[7:5] == RegionTag) begin
      nxt.region = {3'b000, b[4:0]};
    end else if (b[7:6] == DataTag) begin
      nxt.pend  = b[5:0];
      nxt.phase = PH_DATA2;
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/pixel_chip_stream_decoder.sv =====
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | data_byte_i, block_start_i, plane_i
// out     | output    | out_valid_o / out_stall_i | kind_o, hit_plane_o, column_o, row_o, value_o
// cfg     | input     | cfg_we_i                  | cfg_wdata_i (tick_ps)
//
// One item per cycle sustained while the output is not stalled; an accepted item passes
// the input register, then decode and one 32x16 multiply, into the output register.
// Reset clears the parse state, region to 255 and tick_ps to 25000.
// While a result waits under stall, one more item is still taken into the
// input register; the input side stalls only when both registers are full.
module pixel_chip_stream_decoder #(
  parameter int unsigned PLANE_COUNT = pcsd_pkg::PlaneCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        block_start_i,
  input  logic [1:0]  plane_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  hit_plane_o,
  output logic [12:0] column_o,
  output logic [8:0]  row_o,
  output logic [47:0] value_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import pcsd_pkg::*;

  logic        s1_valid_q;
  item_t       s1_item_q;
  logic        advance;
  logic        s1_load;
  logic [15:0] tick_q;
  result_t     res;
  result_t     out_q;
  logic        out_valid_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || advance;
  assign in_stall_o = !s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TickPsReset;
    end else if (cfg_we_i) begin
      tick_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_item_q <= '{data_byte: data_byte_i, block_start: block_start_i, plane: plane_i};
    end
  end

  pcsd_parser #(
    .PLANE_COUNT(PLANE_COUNT)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_valid_q && advance),
    .item_i   (s1_item_q),
    .tick_ps_i(tick_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign hit_plane_o = out_q.plane;
  assign column_o    = out_q.column;
  assign row_o       = out_q.row;
  assign value_o     = out_q.value;

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without both stages full");

  a_trig_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_TRIG) |-> (out_q.value[47:32] == 16'd0))
    else $error("trigger number wider than 32 bits");

  a_hit_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_HIT) |-> (out_q.value == 48'd0))
    else $error("pixel hit carries a value");

  a_hdr_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind != KIND_HIT) |-> (out_q.column == 13'd0 && out_q.row == 9'd0))
    else $error("header result carries pixel address");

endmodule

// ===== rtl/pcsd_parser.sv =====
module pcsd_parser #(
  parameter int unsigned PLANE_COUNT = pcsd_pkg::PlaneCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  pcsd_pkg::item_t   item_i,
  input  logic [15:0]       tick_ps_i,
  output pcsd_pkg::result_t res_o
);
  import pcsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [47:0] acc_q, acc_d;
  logic [7:0]  region_q, region_d;
  logic [5:0]  pend_q, pend_d;
  logic        stop_q, stop_d;

  logic        plane_ok;
  logic [47:0] ts_ticks;
  logic [47:0] ts_ps;
  logic [31:0] trig_num;
  logic [9:0]  addr;
  logic [12:0] hit_col;
  body_t       body_in, body_out;
  logic [7:0]  b;

  assign b        = item_i.data_byte;
  assign plane_ok = 32'(item_i.plane) < PLANE_COUNT;
  assign ts_ticks = {b, acc_q[39:0]};
  assign ts_ps    = (ts_ticks[47:32] == 16'd0) ?
                    48'(ts_ticks[31:0] * tick_ps_i) : 48'd0;
  assign trig_num = {b, acc_q[23:0]};
  assign addr     = {pend_q[1:0], b};
  assign hit_col  = {region_q, 5'd0} + {8'd0, pend_q[5:2], 1'b0} +
                    13'((addr[1:0] == 2'd1) || (addr[1:0] == 2'd2));

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    region_d = region_q;
    pend_d   = pend_q;
    stop_d   = stop_q;
    res_o    = '0;
    res_o.plane = item_i.plane;
    body_in  = '0;
    body_out = '0;
    if (en_i && plane_ok) begin
      if (item_i.block_start) begin
        phase_d  = PH_HDR;
        cnt_d    = '0;
        acc_d    = '0;
        region_d = RegionReset;
        pend_d   = '0;
        stop_d   = 1'b0;
      end
      body_in = '{phase: PH_BODY, region: region_d, pend: pend_d, stop: stop_d};
      body_out = body_byte(body_in, b);
      if (!stop_d) begin
        unique case (phase_d)
          PH_HDR, PH_TSCHK: begin
            if (b == TrigHdrByte && phase_d == PH_HDR) begin
              phase_d = PH_TRIG;
              cnt_d   = '0;
              acc_d   = '0;
            end else if (b == TsHdrByte) begin
              phase_d = PH_TS;
              cnt_d   = '0;
              acc_d   = '0;
            end else begin
              phase_d  = body_out.phase;
              region_d = body_out.region;
              pend_d   = body_out.pend;
              stop_d   = body_out.stop;
            end
          end
          PH_TRIG: begin
            acc_d[cnt_d[1:0]*8 +: 8] = b;
            if (cnt_d == TrigLast) begin
              phase_d     = PH_TSCHK;
              cnt_d       = '0;
              res_o.valid = 1'b1;
              res_o.kind  = KIND_TRIG;
              res_o.value = {16'd0, trig_num};
            end else begin
              cnt_d = cnt_d + 3'd1;
            end
          end
          PH_TS: begin
            acc_d[cnt_d*8 +: 8] = b;
            if (cnt_d == TsLast) begin
              phase_d     = PH_BODY;
              cnt_d       = '0;
              res_o.valid = 1'b1;
              res_o.kind  = KIND_TS;
              res_o.value = ts_ps;
            end else begin
              cnt_d = cnt_d + 3'd1;
            end
          end
          PH_DATA2: begin
            phase_d      = PH_BODY;
            res_o.valid  = 1'b1;
            res_o.kind   = KIND_HIT;
            res_o.column = hit_col;
            res_o.row    = addr[9:1];
          end
          PH_SKIP: begin
            phase_d = PH_BODY;
          end
          default: begin
            phase_d  = body_out.phase;
            region_d = body_out.region;
            pend_d   = body_out.pend;
            stop_d   = body_out.stop;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      cnt_q    <= '0;
      acc_q    <= '0;
      region_q <= RegionReset;
      pend_q   <= '0;
      stop_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      region_q <= region_d;
      pend_q   <= pend_d;
      stop_q   <= stop_d;
    end
  end

endmodule
